>>> sv/trt_pkg.sv
// Package of shared types and constants for the per-dimension trimmed range tracker.
package trt_pkg;

  localparam int MAX_DIMS = 256;
  localparam int MAX_KEEP = 64;

  localparam int ROW_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SLOT_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int ADDR_W = ROW_W + SLOT_W;

  localparam int VAL_W    = 32;
  localparam int DIM_W    = 8;
  localparam int MODE_W   = 2;
  localparam int KEEP_W   = 7;
  localparam int ACT_W    = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  typedef logic signed [VAL_W-1:0] sample_t;

  localparam sample_t MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
  localparam sample_t MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE  = 1'd1;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    sample_t           wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    sample_t          upper;
    sample_t          lower;
  } result_t;

endpackage

>>> sv/trt_ram.sv
// Single list store: one write port and one registered read port.
module trt_ram
  import trt_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output sample_t  rdata_o
);

  sample_t mem [2**ADDR_W];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/trt_ctrl.sv
// Sequencer for sorted insertion walks, bound reads and clears, with per-row valid bits.
module trt_ctrl
  import trt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [DIM_W-1:0]  dim_index_i,
  input  sample_t           sample_value_i,
  input  logic [KEEP_W-1:0] ignore_count_i,
  input  logic [ACT_W-1:0]  dims_in_use_i,
  output mem_req_t          high_req_o,
  output mem_req_t          low_req_o,
  input  sample_t           high_rdata_i,
  input  sample_t           low_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_READ = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [MAX_DIMS-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [DIM_W-1:0]    dim_q, dim_d;
  logic                row_ok_q, row_ok_d;
  logic                found_h_q, found_h_d;
  logic                found_l_q, found_l_d;
  sample_t             carry_h_q, carry_h_d;
  sample_t             carry_l_q, carry_l_d;

  logic              accept;
  logic [ROW_W-1:0]  in_row;
  logic              dim_ok;
  logic              dim_active;
  logic [SLOT_W-1:0] rank_slot;
  sample_t           hv, lv;
  logic              take_h, take_l;
  logic              last_slot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_row     = ROW_W'(dim_index_i);
  assign dim_ok     = (32'(dim_index_i) < MAX_DIMS);
  assign dim_active = dim_ok && ({1'b0, dim_index_i} < dims_in_use_i);
  assign last_slot  = (slot_q == SLOT_W'(MAX_KEEP - 1));

  always_comb begin
    if (ignore_count_i == '0) begin
      rank_slot = '0;
    end else if (32'(ignore_count_i) > MAX_KEEP) begin
      rank_slot = SLOT_W'(MAX_KEEP - 1);
    end else begin
      rank_slot = SLOT_W'(ignore_count_i - KEEP_W'(1));
    end
  end

  assign hv     = row_ok_q ? high_rdata_i : MOST_NEG;
  assign lv     = row_ok_q ? low_rdata_i : MOST_POS;
  assign take_h = found_h_q || (hv < carry_h_q);
  assign take_l = found_l_q || (lv > carry_l_q);

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    slot_d    = slot_q;
    row_d     = row_q;
    dim_d     = dim_q;
    row_ok_d  = row_ok_q;
    found_h_d = found_h_q;
    found_l_d = found_l_q;
    carry_h_d = carry_h_q;
    carry_l_d = carry_l_q;
    high_req_o = '0;
    low_req_o  = '0;
    res_valid_o = 1'b0;
    res_o.dim   = dim_q;
    res_o.upper = hv;
    res_o.lower = lv;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_INSERT: begin
              if (dim_active) begin
                high_req_o.re    = 1'b1;
                high_req_o.raddr = {in_row, SLOT_W'(0)};
                row_d     = in_row;
                row_ok_d  = valid_q[in_row];
                slot_d    = '0;
                found_h_d = 1'b0;
                found_l_d = 1'b0;
                carry_h_d = sample_value_i;
                carry_l_d = sample_value_i;
                state_d   = ST_WALK;
              end
            end
            MODE_READ: begin
              high_req_o.re    = 1'b1;
              high_req_o.raddr = {in_row, rank_slot};
              dim_d    = dim_index_i;
              row_ok_d = dim_ok && valid_q[in_row];
              state_d  = ST_READ;
            end
            MODE_CLEAR: begin
              for (int r = 0; r < MAX_DIMS; r++) begin
                if (32'(dims_in_use_i) > r) begin
                  valid_d[r] = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
          low_req_o.re    = high_req_o.re;
          low_req_o.raddr = high_req_o.raddr;
        end
      end
      ST_WALK: begin
        high_req_o.we    = 1'b1;
        high_req_o.waddr = {row_q, slot_q};
        high_req_o.wdata = take_h ? carry_h_q : hv;
        low_req_o.we     = 1'b1;
        low_req_o.waddr  = {row_q, slot_q};
        low_req_o.wdata  = take_l ? carry_l_q : lv;
        found_h_d = take_h;
        found_l_d = take_l;
        carry_h_d = take_h ? hv : carry_h_q;
        carry_l_d = take_l ? lv : carry_l_q;
        if (last_slot) begin
          valid_d[row_q] = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          high_req_o.re    = 1'b1;
          high_req_o.raddr = {row_q, slot_q + SLOT_W'(1)};
          low_req_o.re     = 1'b1;
          low_req_o.raddr  = {row_q, slot_q + SLOT_W'(1)};
          slot_d           = slot_q + SLOT_W'(1);
        end
      end
      ST_READ: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    row_q     <= row_d;
    dim_q     <= dim_d;
    row_ok_q  <= row_ok_d;
    found_h_q <= found_h_d;
    found_l_q <= found_l_d;
    carry_h_q <= carry_h_d;
    carry_l_q <= carry_l_d;
  end

endmodule

>>> sv/per_dimension_trimmed_range_tracker_unit.sv
// Top level of the per-dimension trimmed range tracker: configuration, stores and result register.
//
// One input channel (valid/ready) carries a mode, a dimension and a Q16.16 sample.
// Insert places the sample in the sorted upper and lower lists of its dimension;
// read returns the K-th largest and K-th smallest value of a dimension on the
// output channel; clear empties every active dimension. Only a read gives a result.
// An insert into an active dimension walks every slot of the dimension's row, one slot per
// cycle through the single read and write port of each list store. A read fetches its
// bounds through the registered read ports of the list stores and loads them into the
// output register once it is free. A clear, an ignored sample and the unused mode leave
// the block idle.
// The output register holds a result while the receiver stalls; inserts and clears
// are still taken meanwhile, and a further read is taken but then holds the input
// until the register is free.
// Reset clears the per-row valid bits at once, so every row reads as sentinels and no clearing
// pass is needed; K resets to 1 and the active dimension count to 256. Configuration is written
// through a plain write port by the user, only while the block is idle, which it does not enforce.
module per_dimension_trimmed_range_tracker_unit
  import trt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [DIM_W-1:0]      dim_index_i,
  input  sample_t               sample_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIM_W-1:0]      dim_out_o,
  output sample_t               upper_value_o,
  output sample_t               lower_value_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [KEEP_W-1:0] ignore_count_q;
  logic [ACT_W-1:0]  dims_in_use_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  mem_req_t high_req, low_req;
  sample_t  high_rdata, low_rdata;
  logic     res_valid, res_ready;
  result_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_count_q <= KEEP_W'(1);
      dims_in_use_q  <= ACT_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IGNORE_COUNT: ignore_count_q <= cfg_data_i[KEEP_W-1:0];
        CFG_DIMS_IN_USE:  dims_in_use_q  <= cfg_data_i[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  trt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .dim_index_i    (dim_index_i),
    .sample_value_i (sample_value_i),
    .ignore_count_i (ignore_count_q),
    .dims_in_use_i  (dims_in_use_q),
    .high_req_o     (high_req),
    .low_req_o      (low_req),
    .high_rdata_i   (high_rdata),
    .low_rdata_i    (low_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  trt_ram u_high_ram (
    .clk_i   (clk_i),
    .req_i   (high_req),
    .rdata_o (high_rdata)
  );

  trt_ram u_low_ram (
    .clk_i   (clk_i),
    .req_i   (low_req),
    .rdata_o (low_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dim_out_o     = out_q.dim;
  assign upper_value_o = out_q.upper;
  assign lower_value_o = out_q.lower;

  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && ((mode_i == MODE_READ) ||
     ((mode_i == MODE_INSERT) && (32'(dim_index_i) < MAX_DIMS) &&
      ({1'b0, dim_index_i} < dims_in_use_q)))) |=> !in_ready_o)
    else $error("block took a new transaction during a walk or read");

  a_clear_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_CLEAR)) |=> in_ready_o)
    else $error("clear did not complete in one cycle");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (out_valid_o && in_ready_o))
    else $error("finished read did not reach the output register");

endmodule
